// ----- hdl/distab_pkg.sv -----
package distab_pkg;

    localparam int ENTRIES   = 64;
    localparam int KEY_BITS  = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int COUNT_W   = $clog2(ENTRIES + 1);
    localparam int DEPTH_W   = 4;
    localparam int DEPTH_MAX = KEY_BITS - 1;
    localparam int STATUS_W  = 2;
    localparam int WORD_W    = 3 * KEY_BITS;

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

endpackage

// ----- hdl/distab_if.sv -----
interface distab_in_if;
    import distab_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [KEY_BITS-1:0] node_key;

    modport source (output valid, output func, output node_key, input ready);
    modport sink   (input valid, input func, input node_key, output ready);
endinterface

interface distab_out_if;
    import distab_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [KEY_BITS-1:0] matched_node;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output found, output matched_node, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input matched_node, input status,
                    input entry_count, output ready);
endinterface

interface distab_cfg_if;
    import distab_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/dyadic_interval_stab_table.sv -----
// Sequence: a lookup scans every entry and then registers its result for the output;
// an insert first doubles the node down to the leaf level (up to KEY_BITS - 1 doubling
// steps), then scans and writes; a node zero insert answers with neither step. One item at a time.
// The scan reads the entry memory through its single read port, one entry per cycle.
// Reset: table empty (valid bits and count cleared), tree_depth 0, no result held.
// Memory contents are not cleared; entries are only read behind their valid bit.
module dyadic_interval_stab_table (
    input  logic          clk,
    input  logic          rst_n,
    distab_in_if.sink     req,
    distab_out_if.source  rsp,
    distab_cfg_if.sink    cfg
);
    import distab_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_NORM, S_SCAN, S_WRITE, S_DONE} state_t;

    state_t state_reg, state_next;

    logic [DEPTH_W-1:0]  tree_depth_reg;
    logic [ENTRIES-1:0]  entry_valid_reg, entry_valid_next;
    logic [COUNT_W-1:0]  valid_count_reg, valid_count_next;

    logic                func_reg, func_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] first_reg, first_next;
    logic [KEY_BITS-1:0] span_reg, span_next;
    logic [KEY_BITS-1:0] last_reg, last_next;

    logic [IDX_W:0]      issue_cnt_reg, issue_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;

    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                free_reg, free_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [KEY_BITS-1:0] best_last_reg, best_last_next;
    logic [KEY_BITS-1:0] best_first_reg, best_first_next;
    logic [KEY_BITS-1:0] best_node_reg, best_node_next;

    logic                res_found_reg, res_found_next;
    logic [KEY_BITS-1:0] res_node_reg, res_node_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [KEY_BITS-1:0] out_node_reg, out_node_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic [WORD_W-1:0]   mem [ENTRIES];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic [DEPTH_W-1:0]  eff_depth;
    logic [KEY_BITS-1:0] leaf_start;
    logic [KEY_BITS-1:0] rd_last, rd_first, rd_node;
    logic                ent_ok;
    logic                in_beat;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign in_beat   = req.valid && req.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.matched_node = out_node_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.entry_count  = out_count_reg;

    assign eff_depth  = (32'(tree_depth_reg) > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX)
                                                          : tree_depth_reg;
    assign leaf_start = KEY_BITS'(1) << eff_depth;

    assign rd_last  = rd_data_reg[3*KEY_BITS-1:2*KEY_BITS];
    assign rd_first = rd_data_reg[2*KEY_BITS-1:KEY_BITS];
    assign rd_node  = rd_data_reg[KEY_BITS-1:0];
    assign ent_ok   = cmp_vld_reg && entry_valid_reg[cmp_idx_reg];

    always_comb
    begin
        state_next       = state_reg;
        entry_valid_next = entry_valid_reg;
        valid_count_next = valid_count_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        first_next       = first_reg;
        span_next        = span_reg;
        last_next        = last_reg;
        issue_cnt_next   = issue_cnt_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        best_last_next   = best_last_reg;
        best_first_next  = best_first_reg;
        best_node_next   = best_node_reg;
        res_found_next   = res_found_reg;
        res_node_next    = res_node_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_found_next   = out_found_reg;
        out_node_next    = out_node_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = hit_reg ? hit_idx_reg : free_idx_reg;
        mem_wdata        = {last_reg, first_reg, key_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    func_next      = req.func;
                    key_next       = req.node_key;
                    first_next     = req.node_key;
                    span_next      = KEY_BITS'(1);
                    last_next      = req.node_key;
                    issue_cnt_next = '0;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    if (req.func == FN_LOOKUP)
                        state_next = S_SCAN;
                    else if (req.node_key == '0)
                    begin
                        res_found_next  = 1'b0;
                        res_node_next   = '0;
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // one doubling per cycle down to the leaf level
                if (first_reg < leaf_start)
                begin
                    first_next = first_reg << 1;
                    span_next  = span_reg << 1;
                end
                else
                begin
                    last_next  = first_reg + span_reg - KEY_BITS'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue_cnt_reg < (IDX_W+1)'(ENTRIES))
                begin
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!cmp_vld_reg)
                    state_next = S_WRITE;

                if (func_reg == FN_INSERT)
                begin
                    if (ent_ok && rd_last == last_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                    end
                    if (cmp_vld_reg && !entry_valid_reg[cmp_idx_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
                else if (ent_ok && rd_last >= key_reg &&
                         (!hit_reg || rd_last < best_last_reg))
                begin
                    hit_next        = 1'b1;
                    best_last_next  = rd_last;
                    best_first_next = rd_first;
                    best_node_next  = rd_node;
                end
            end
            S_WRITE:
            begin
                state_next = S_DONE;
                if (func_reg == FN_INSERT)
                begin
                    res_found_next  = 1'b0;
                    res_node_next   = '0;
                    res_status_next = ST_OK;
                    if (hit_reg)
                        mem_we = 1'b1;
                    else if (free_reg)
                    begin
                        mem_we                          = 1'b1;
                        entry_valid_next[free_idx_reg]  = 1'b1;
                        valid_count_next                = valid_count_reg + 1'b1;
                    end
                    else
                        res_status_next = ST_FULL;
                end
                else
                begin
                    res_found_next  = hit_reg && (best_first_reg <= key_reg);
                    res_node_next   = (hit_reg && (best_first_reg <= key_reg))
                                      ? best_node_reg : '0;
                    res_status_next = ST_OK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_node_next   = res_node_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = valid_count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tree_depth_reg  <= '0;
            entry_valid_reg <= '0;
            valid_count_reg <= '0;
            issue_cnt_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            free_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg.valid && cfg.ready)
                tree_depth_reg <= cfg.data;
            entry_valid_reg <= entry_valid_next;
            valid_count_reg <= valid_count_next;
            issue_cnt_reg   <= issue_cnt_next;
            cmp_vld_reg     <= cmp_vld_next;
            hit_reg         <= hit_next;
            free_reg        <= free_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        first_reg      <= first_next;
        span_reg       <= span_next;
        last_reg       <= last_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        best_last_reg  <= best_last_next;
        best_first_reg <= best_first_next;
        best_node_reg  <= best_node_next;
        res_found_reg  <= res_found_next;
        res_node_reg   <= res_node_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_node_reg   <= out_node_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[issue_cnt_reg[IDX_W-1:0]];
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(entry_valid_reg) == 32'(valid_count_reg))
        else $error("valid count out of step with valid bits");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.entry_count == COUNT_W'(ENTRIES))
        else $error("full status with free slots");

    a_hit_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.status == ST_OK && rsp.matched_node != '0)
        else $error("hit with bad status or node");

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NORM |-> first_reg != '0)
        else $error("doubling a zero node");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> !mem_we && state_reg == S_DONE)
        else $error("memory written outside the write step");

endmodule
